// ===== rtl/csp_pkg.sv =====
// Shared types and constants for the subsample pattern classifier.
package csp_pkg;

	// Cipher block geometry
	localparam int BLOCK_BYTES = 16;
	localparam int BLOCK_SHIFT = 4;
	localparam int BYTE_POS_W  = 4;
	localparam int CTR_W       = 64;
	localparam int BYTE_W      = 8;

	// Decoupling queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Cipher mode codes
	localparam logic MODE_CTR = 1'b0;
	localparam logic MODE_CBC = 1'b1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_CIPHER_MODE  = 2'd0,
		REG_CRYPT_BLOCKS = 2'd1,
		REG_SKIP_BLOCKS  = 2'd2
	} cfg_reg_t;

	// Live configuration
	typedef struct packed {
		logic       cipher_mode;
		logic [3:0] crypt_blocks;
		logic [3:0] skip_blocks;
	} cfg_t;

	// One classified byte on its way from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              prot;
		logic              err;
		logic              sample_start;
		logic              restart_set;
		logic [CTR_W-1:0]  counter_start;
	} csp_entry_t;

endpackage

// ===== rtl/cenc_subsample_pattern_classifier.sv =====
// Top level of the subsample pattern classifier: config registers and stream ports.
//
//   channel   direction  accepted when                    payload
//   s_axis    in         s_axis_tvalid & s_axis_tready    one sample byte and descriptors
//   m_axis    out        m_axis_tvalid & m_axis_tready    one tagged byte
//   cfg       in         cfg_we                           one register write
//
// One byte per cycle sustained while m_axis_tready stays high. The accepting edge
// classifies a byte into the queue; from the queue head it moves into the back end's
// output register, which drives m_axis_tvalid, once that register is empty or taken.
// A four-entry queue lets the front keep accepting while m_axis stalls; s_axis_tready
// drops only when the queue is full. Reset clears all counters, the queue and the
// output valid, and sets the pending IV reload mark. No clearing pass after reset.
module cenc_subsample_pattern_classifier #(
	parameter int LENGTH_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [7:0] in_byte, [39:8] clear_length, [71:40] protected_length,
	// [135:72] counter_start
	input  logic [135:0] s_axis_tdata,
	// [0] sample_start, [1] subsample_start
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] out_byte, [71:8] block_counter, [75:72] byte_in_block, [79:76] zero
	output logic [79:0]  m_axis_tdata,
	// [0] is_protected, [1] chain_restart, [2] framing_error
	output logic [2:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [3:0]   cfg_data
);
	import csp_pkg::*;

	cfg_t       cfg_q;
	csp_entry_t f_entry, q_head;
	logic       q_full, q_valid, q_pop, s_fire;

	logic [7:0]  out_byte;
	logic        is_protected, chain_restart, framing_error;
	logic [63:0] block_counter;
	logic [3:0]  byte_in_block;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CIPHER_MODE:  cfg_q.cipher_mode  <= cfg_data[0];
				REG_CRYPT_BLOCKS: cfg_q.crypt_blocks <= cfg_data;
				REG_SKIP_BLOCKS:  cfg_q.skip_blocks  <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign s_axis_tready = !q_full;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	csp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.fire             (s_fire),
		.in_byte          (s_axis_tdata[7:0]),
		.sample_start     (s_axis_tuser[0]),
		.subsample_start  (s_axis_tuser[1]),
		.clear_length     (s_axis_tdata[39:8]),
		.protected_length (s_axis_tdata[71:40]),
		.counter_start    (s_axis_tdata[135:72]),
		.entry            (f_entry)
	);

	csp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_fire),
		.push_data (f_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	csp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_entry       (q_head),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (out_byte),
		.is_protected  (is_protected),
		.block_counter (block_counter),
		.byte_in_block (byte_in_block),
		.chain_restart (chain_restart),
		.framing_error (framing_error)
	);

	assign m_axis_tdata = {4'b0000, byte_in_block, block_counter, out_byte};
	assign m_axis_tuser = {framing_error, chain_restart, is_protected};

endmodule

// ===== rtl/csp_front.sv =====
// Front end: subsample length bookkeeping and clear/protected classification.
module csp_front #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csp_pkg::cfg_t       cfg,
	input  logic                fire,
	input  logic [7:0]          in_byte,
	input  logic                sample_start,
	input  logic                subsample_start,
	input  logic [31:0]         clear_length,
	input  logic [31:0]         protected_length,
	input  logic [63:0]         counter_start,
	output csp_pkg::csp_entry_t entry
);
	import csp_pkg::*;

	localparam int FB_W = LENGTH_BITS - BLOCK_SHIFT;

	logic [LENGTH_BITS-1:0] clear_left_q, protected_left_q;
	logic [FB_W-1:0]        full_block_left_q;
	logic [4:0]             stripe_block_pos_q;
	logic [BYTE_POS_W-1:0]  stripe_byte_pos_q;

	logic [LENGTH_BITS-1:0] clr_ext, prt_ext;
	logic [LENGTH_BITS-1:0] cl, pl, cl_d, pl_d;
	logic [FB_W-1:0]        fb, fb_d;
	logic [4:0]             sbp, sbp_d, sbp_inc, period;
	logic [BYTE_POS_W-1:0]  sbyte, sbyte_d;
	logic                   pattern, prot, err;

	assign clr_ext = LENGTH_BITS'(clear_length);
	assign prt_ext = LENGTH_BITS'(protected_length);
	assign pattern = (cfg.crypt_blocks != 4'd0);
	assign period  = {1'b0, cfg.crypt_blocks} + {1'b0, cfg.skip_blocks};
	assign sbp_inc = sbp + 5'd1;

	// Subsample start reloads lengths and the stripe position
	always_comb begin
		cl    = subsample_start ? clr_ext : clear_left_q;
		pl    = subsample_start ? prt_ext : protected_left_q;
		fb    = subsample_start ? prt_ext[LENGTH_BITS-1:BLOCK_SHIFT] : full_block_left_q;
		sbp   = subsample_start ? 5'd0 : stripe_block_pos_q;
		sbyte = subsample_start ? '0 : stripe_byte_pos_q;
	end

	// Classification and next state
	always_comb begin
		cl_d    = cl;
		pl_d    = pl;
		fb_d    = fb;
		sbp_d   = sbp;
		sbyte_d = sbyte;
		prot    = 1'b0;
		err     = 1'b0;
		if (cl != '0) begin
			cl_d = cl - LENGTH_BITS'(1);
		end else if (pl != '0) begin
			pl_d = pl - LENGTH_BITS'(1);
			if (fb != '0) begin
				prot    = pattern ? (sbp < {1'b0, cfg.crypt_blocks}) : 1'b1;
				sbyte_d = sbyte + BYTE_POS_W'(1);
				if (sbyte == '1) begin
					fb_d  = fb - FB_W'(1);
					sbp_d = (sbp_inc >= period) ? 5'd0 : sbp_inc;
				end
			end else begin
				// partial tail: only full-sample counter mode protects it
				prot = !pattern && (cfg.cipher_mode == MODE_CTR);
			end
		end else begin
			err = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_left_q       <= '0;
			protected_left_q   <= '0;
			full_block_left_q  <= '0;
			stripe_block_pos_q <= '0;
			stripe_byte_pos_q  <= '0;
		end else if (fire) begin
			clear_left_q       <= cl_d;
			protected_left_q   <= pl_d;
			full_block_left_q  <= fb_d;
			stripe_block_pos_q <= sbp_d;
			stripe_byte_pos_q  <= sbyte_d;
		end
	end

	// Entry handed to the queue
	always_comb begin
		entry.data          = in_byte;
		entry.prot          = prot;
		entry.err           = err;
		entry.sample_start  = sample_start;
		entry.restart_set   = subsample_start && (cfg.cipher_mode == MODE_CBC) && pattern;
		entry.counter_start = counter_start;
	end

endmodule

// ===== rtl/csp_queue.sv =====
// Short register queue between the front and the back end.
module csp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  csp_pkg::csp_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output csp_pkg::csp_entry_t head
);
	import csp_pkg::*;

	csp_entry_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/csp_back.sv =====
// Back end: keystream counter, byte position, IV reload mark and output register.
module csp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  csp_pkg::cfg_t       cfg,
	input  logic                q_valid,
	input  csp_pkg::csp_entry_t q_entry,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                is_protected,
	output logic [63:0]         block_counter,
	output logic [3:0]          byte_in_block,
	output logic                chain_restart,
	output logic                framing_error
);
	import csp_pkg::*;

	logic [CTR_W-1:0]      ks_ctr_q, ks_base;
	logic [BYTE_POS_W-1:0] ks_pos_q, ks_pos_base;
	logic                  pend_q, pend_base;
	logic                  valid_q;

	logic [BYTE_W-1:0]     byte_q;
	logic                  prot_q, rst_q, err_q;
	logic [CTR_W-1:0]      ctr_q;
	logic [BYTE_POS_W-1:0] bib_q;

	// Output register frees when empty or being taken
	assign q_pop = q_valid && (!valid_q || out_ready);

	// Sample start reloads the counter before the byte is tagged
	always_comb begin
		ks_base     = q_entry.sample_start ? q_entry.counter_start : ks_ctr_q;
		ks_pos_base = q_entry.sample_start ? '0 : ks_pos_q;
		pend_base   = pend_q || q_entry.sample_start || q_entry.restart_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_ctr_q <= '0;
			ks_pos_q <= '0;
			pend_q   <= 1'b1;
			valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				if (q_entry.prot) begin
					pend_q   <= 1'b0;
					ks_pos_q <= ks_pos_base + BYTE_POS_W'(1);
					ks_ctr_q <= (ks_pos_base == '1) ? ks_base + CTR_W'(1) : ks_base;
				end else begin
					pend_q   <= pend_base;
					ks_pos_q <= ks_pos_base;
					ks_ctr_q <= ks_base;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q <= q_entry.data;
			prot_q <= q_entry.prot;
			err_q  <= q_entry.err;
			ctr_q  <= (q_entry.prot && cfg.cipher_mode == MODE_CTR) ? ks_base : '0;
			bib_q  <= q_entry.prot ? ks_pos_base : '0;
			rst_q  <= q_entry.prot && pend_base;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign is_protected  = prot_q;
	assign block_counter = ctr_q;
	assign byte_in_block = bib_q;
	assign chain_restart = rst_q;
	assign framing_error = err_q;

endmodule
